// ===== hw/rtl/mer_pkg.sv =====
// Shared widths, types and codes for the midpoint ellipse rasterizer.
package mer_pkg;

   localparam int COORD_BITS = 12;
   localparam int PIX_BITS   = COORD_BITS + 2;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int PROD_BITS  = 3 * COORD_BITS;
   localparam int GRAD_BITS  = 3 * COORD_BITS + 4;
   localparam int DEC_BITS   = 4 * COORD_BITS;
   localparam int COLOR_BITS = 24;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [PROD_BITS-1:0]         prod_type;
   typedef logic signed [GRAD_BITS-1:0]  grad_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;
   typedef logic signed [PIX_BITS-1:0]   pix_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

   typedef enum logic [1:0] {
      MUL_A_A,
      MUL_B_B,
      MUL_ASQ_B,
      MUL_BSQ_A
   } mul_sel_type;

   typedef enum logic [2:0] {
      PIX_CENTER,
      PIX_PP,
      PIX_MP,
      PIX_PM,
      PIX_MM
   } pix_sel_type;

   typedef struct packed {
      logic        ld_start;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        ld_asq;
      logic        ld_bsq;
      logic        init1;
      logic        init2;
      logic        step_grad;
      logic        step_dec;
      logic        region2;
      logic        out_load;
      pix_sel_type pix_sel;
   } cmd_type;

   typedef struct packed {
      logic gx_lt_gy;
      logic gx_gt_gy;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer.
//
//  channel  direction  handshake          payload
//  req_     in         valid / stall      opcode, center_x, center_y, radius_x, radius_y
//  rsp_     out        valid / stall      pixel_x, pixel_y, color, last, finished
//  csr_     in         valid / ready      draw_color
//
// Start request: three passes through the one 24x12 multiplier, then the decision
// init, then 5 pixels at one per cycle when not stalled.
// Step request: gradient update, then decision update, then 4 pixels.
// Region switch step: one multiply, then init, then 4 pixels.
// A step with no ellipse active is accepted and produces nothing.
// Requests are taken only between items; rsp_stall holds the output register.
// Reset is synchronous and clears the controller, the draw color and the output valid.
module midpoint_ellipse_rasterizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  mer_pkg::coord_type  req_center_x,
   input  mer_pkg::coord_type  req_center_y,
   input  mer_pkg::coord_type  req_radius_x,
   input  mer_pkg::coord_type  req_radius_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mer_pkg::pix_type    rsp_pixel_x,
   output mer_pkg::pix_type    rsp_pixel_y,
   output mer_pkg::color_type  rsp_color,
   output logic                rsp_last,
   output logic                rsp_finished,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  mer_pkg::color_type  csr_draw_color
);
   import mer_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   mer_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .csr_write      (csr_valid && csr_ready),
      .csr_draw_color (csr_draw_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_color      (rsp_color),
      .rsp_last       (rsp_last),
      .rsp_finished   (rsp_finished)
   );

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
// Sequencing state machine of the ellipse rasterizer.
module mer_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  mer_pkg::status_type sts,
   output mer_pkg::cmd_type    cmd
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_MUL_AB,
      ST_INIT1,
      ST_R2_MUL,
      ST_R2_INIT,
      ST_STEP_G,
      ST_STEP_D,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_R2_START,
      PH_R2
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic        rgn2_ff, rgn2_in;
   pix_sel_type sel_ff, sel_in;
   logic        accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rgn2_in  = rgn2_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_A_A;
      cmd.pix_sel = sel_ff;
      cmd.region2 = rgn2_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_START) begin
                  cmd.ld_start = 1'b1;
                  rgn2_in      = 1'b0;
                  state_in     = ST_MUL_AA;
               end else begin
                  case (phase_ff)
                     PH_R1: begin
                        rgn2_in  = 1'b0;
                        state_in = ST_STEP_G;
                     end
                     PH_R2_START: begin
                        rgn2_in  = 1'b1;
                        state_in = ST_R2_MUL;
                     end
                     PH_R2: begin
                        rgn2_in  = 1'b1;
                        state_in = ST_STEP_G;
                     end
                     default: state_in = ST_IDLE;  // step with no ellipse: dropped
                  endcase
               end
            end
         end
         ST_MUL_AA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_A_A;
            state_in    = ST_MUL_BB;
         end
         ST_MUL_BB: begin
            cmd.ld_asq  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B_B;
            state_in    = ST_MUL_AB;
         end
         ST_MUL_AB: begin
            cmd.ld_bsq  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ASQ_B;
            state_in    = ST_INIT1;
         end
         ST_INIT1: begin
            cmd.init1 = 1'b1;
            sel_in    = PIX_CENTER;
            state_in  = ST_EMIT;
         end
         ST_R2_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BSQ_A;
            state_in    = ST_R2_INIT;
         end
         ST_R2_INIT: begin
            cmd.init2 = 1'b1;
            sel_in    = PIX_PP;
            state_in  = ST_EMIT;
         end
         ST_STEP_G: begin
            cmd.step_grad = 1'b1;
            state_in      = ST_STEP_D;
         end
         ST_STEP_D: begin
            cmd.step_dec = 1'b1;
            sel_in       = PIX_PP;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               case (sel_ff)
                  PIX_CENTER: sel_in = PIX_PP;
                  PIX_PP:     sel_in = PIX_MP;
                  PIX_MP:     sel_in = PIX_PM;
                  PIX_PM:     sel_in = PIX_MM;
                  default: begin
                     state_in = ST_IDLE;
                     // gradients are settled here; pick the next walk phase
                     if (rgn2_ff)
                        phase_in = sts.gx_gt_gy ? PH_R2 : PH_IDLE;
                     else
                        phase_in = sts.gx_lt_gy ? PH_R1 : PH_R2_START;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         rgn2_ff  <= 1'b0;
         sel_ff   <= PIX_CENTER;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rgn2_ff  <= rgn2_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== hw/rtl/mer_dpath.sv =====
// Datapath: walk registers, shared multiplier, decision update and pixel output register.
module mer_dpath (
   input  logic                clock,
   input  logic                reset,
   input  mer_pkg::cmd_type    cmd,
   output mer_pkg::status_type sts,
   input  mer_pkg::coord_type  req_center_x,
   input  mer_pkg::coord_type  req_center_y,
   input  mer_pkg::coord_type  req_radius_x,
   input  mer_pkg::coord_type  req_radius_y,
   input  logic                csr_write,
   input  mer_pkg::color_type  csr_draw_color,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mer_pkg::pix_type    rsp_pixel_x,
   output mer_pkg::pix_type    rsp_pixel_y,
   output mer_pkg::color_type  rsp_color,
   output logic                rsp_last,
   output logic                rsp_finished
);
   import mer_pkg::*;

   function automatic grad_type sq2_g(sq_type s);
      return {{(GRAD_BITS-SQ_BITS-1){1'b0}}, s, 1'b0};
   endfunction

   function automatic dec_type grad4_d(grad_type g);
      return {{(DEC_BITS-GRAD_BITS-2){g[GRAD_BITS-1]}}, g, 2'b00};
   endfunction

   function automatic dec_type sq4_d(sq_type s);
      return {{(DEC_BITS-SQ_BITS-2){1'b0}}, s, 2'b00};
   endfunction

   coord_type ctr_x_ff, ctr_x_in, ctr_y_ff, ctr_y_in;
   coord_type semi_a_ff, semi_a_in, semi_b_ff, semi_b_in;
   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   sq_type    asq_ff, asq_in, bsq_ff, bsq_in;
   prod_type  prod_ff, prod_in;
   grad_type  gx_ff, gx_in, gy_ff, gy_in;
   dec_type   dec_ff, dec_in;
   color_type color_ff, color_in;

   logic      valid_ff, valid_in;
   pix_type   px_ff, px_in, py_ff, py_in;
   color_type ocolor_ff, ocolor_in;
   logic      last_ff, last_in, fin_ff, fin_in;

   sq_type    mul_a;
   coord_type mul_b;
   grad_type  prod2_g, lead, lag;
   dec_type   prod4_d, sq_step_d;
   logic      dec_neg;
   pix_type   cx_e, cy_e, ux_e, uy_e;
   pix_type   x_plus, x_minus, y_plus, y_minus;

   assign dec_neg = dec_ff[DEC_BITS-1];
   assign prod2_g = {{(GRAD_BITS-PROD_BITS-1){1'b0}}, prod_ff, 1'b0};
   assign prod4_d = {{(DEC_BITS-PROD_BITS-2){1'b0}}, prod_ff, 2'b00};

   always_comb begin
      case (cmd.mul_sel)
         MUL_A_A: begin
            mul_a = {{COORD_BITS{1'b0}}, semi_a_ff};
            mul_b = semi_a_ff;
         end
         MUL_B_B: begin
            mul_a = {{COORD_BITS{1'b0}}, semi_b_ff};
            mul_b = semi_b_ff;
         end
         MUL_ASQ_B: begin
            mul_a = asq_ff;
            mul_b = semi_b_ff;
         end
         default: begin
            mul_a = bsq_ff;
            mul_b = semi_a_ff;
         end
      endcase
   end

   // region 2 mirrors region 1 with the axes swapped
   assign lead      = cmd.region2 ? gy_ff : gx_ff;
   assign lag       = cmd.region2 ? gx_ff : gy_ff;
   assign sq_step_d = cmd.region2 ? sq4_d(asq_ff) : sq4_d(bsq_ff);

   assign cx_e    = {2'b00, ctr_x_ff};
   assign cy_e    = {2'b00, ctr_y_ff};
   assign ux_e    = {2'b00, cur_x_ff};
   assign uy_e    = {2'b00, cur_y_ff};
   assign x_plus  = cx_e + ux_e;
   assign x_minus = cx_e - ux_e;
   assign y_plus  = cy_e + uy_e;
   assign y_minus = cy_e - uy_e;

   assign sts.gx_lt_gy = (gx_ff < gy_ff);
   assign sts.gx_gt_gy = (gx_ff > gy_ff);
   assign sts.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      ctr_x_in  = ctr_x_ff;
      ctr_y_in  = ctr_y_ff;
      semi_a_in = semi_a_ff;
      semi_b_in = semi_b_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      asq_in    = asq_ff;
      bsq_in    = bsq_ff;
      prod_in   = prod_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      dec_in    = dec_ff;
      color_in  = csr_write ? csr_draw_color : color_ff;

      if (cmd.ld_start) begin
         ctr_x_in  = req_center_x;
         ctr_y_in  = req_center_y;
         semi_a_in = req_radius_x;
         semi_b_in = req_radius_y;
         cur_x_in  = '0;
         cur_y_in  = req_radius_y;
      end
      if (cmd.mul_en)
         prod_in = {{COORD_BITS{1'b0}}, mul_a} * {{SQ_BITS{1'b0}}, mul_b};
      if (cmd.ld_asq)
         asq_in = prod_ff[SQ_BITS-1:0];
      if (cmd.ld_bsq)
         bsq_in = prod_ff[SQ_BITS-1:0];
      if (cmd.init1) begin
         gx_in  = '0;
         gy_in  = prod2_g;
         dec_in = sq4_d(bsq_ff) - prod4_d + {{(DEC_BITS-SQ_BITS){1'b0}}, asq_ff};
      end
      if (cmd.init2) begin
         cur_x_in = semi_a_ff;
         cur_y_in = '0;
         gx_in    = prod2_g;
         gy_in    = '0;
         dec_in   = sq4_d(asq_ff) - prod4_d + {{(DEC_BITS-SQ_BITS){1'b0}}, bsq_ff};
      end
      if (cmd.step_grad) begin
         if (!cmd.region2) begin
            cur_x_in = cur_x_ff + 1'b1;
            gx_in    = gx_ff + sq2_g(bsq_ff);
            if (!dec_neg) begin
               cur_y_in = cur_y_ff - 1'b1;
               gy_in    = gy_ff - sq2_g(asq_ff);
            end
         end else begin
            cur_y_in = cur_y_ff + 1'b1;
            gy_in    = gy_ff + sq2_g(asq_ff);
            if (!dec_neg) begin
               cur_x_in = cur_x_ff - 1'b1;
               gx_in    = gx_ff - sq2_g(bsq_ff);
            end
         end
      end
      // decision still holds its old sign here, gradients are already advanced
      if (cmd.step_dec)
         dec_in = dec_ff + grad4_d(lead) + sq_step_d - (dec_neg ? '0 : grad4_d(lag));
   end

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      px_in     = px_ff;
      py_in     = py_ff;
      ocolor_in = ocolor_ff;
      last_in   = last_ff;
      fin_in    = fin_ff;
      if (cmd.out_load) begin
         valid_in  = 1'b1;
         ocolor_in = color_ff;
         last_in   = (cmd.pix_sel == PIX_MM) || (cmd.pix_sel == PIX_CENTER) && 1'b0;
         fin_in    = (cmd.pix_sel == PIX_MM) && cmd.region2 && !sts.gx_gt_gy;
         case (cmd.pix_sel)
            PIX_CENTER: begin
               px_in = cx_e;
               py_in = cy_e;
            end
            PIX_PP: begin
               px_in = x_plus;
               py_in = y_plus;
            end
            PIX_MP: begin
               px_in = x_minus;
               py_in = y_plus;
            end
            PIX_PM: begin
               px_in = x_plus;
               py_in = y_minus;
            end
            default: begin
               px_in = x_minus;
               py_in = y_minus;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         color_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_x_ff  <= ctr_x_in;
      ctr_y_ff  <= ctr_y_in;
      semi_a_ff <= semi_a_in;
      semi_b_ff <= semi_b_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      asq_ff    <= asq_in;
      bsq_ff    <= bsq_in;
      prod_ff   <= prod_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      dec_ff    <= dec_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      ocolor_ff <= ocolor_in;
      last_ff   <= last_in;
      fin_ff    <= fin_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_pixel_x  = px_ff;
   assign rsp_pixel_y  = py_ff;
   assign rsp_color    = ocolor_ff;
   assign rsp_last     = last_ff;
   assign rsp_finished = fin_ff;

endmodule

// ===== hw/rtl/mer_checker.sv =====
// Port-level checks for the ellipse rasterizer, bound to the top level.
module mer_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_opcode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input mer_pkg::pix_type   rsp_pixel_x,
   input mer_pkg::pix_type   rsp_pixel_y,
   input logic               rsp_last,
   input logic               rsp_finished
);
   import mer_pkg::*;

   // a held pixel stays put while the sink stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))
      else $error("rsp payload changed under stall");

   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_last)
      else $error("finished pixel without last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a start request holds off further requests once it is taken
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_START) |=> req_stall ##1 req_stall)
      else $error("start request did not hold off the next request");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_opcode   (req_opcode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_pixel_x  (rsp_pixel_x),
   .rsp_pixel_y  (rsp_pixel_y),
   .rsp_last     (rsp_last),
   .rsp_finished (rsp_finished)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the midpoint ellipse rasterizer: pixel predictor plus random traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mer_pkg::*;

   typedef struct {
      pix_type   px;
      pix_type   py;
      color_type color;
      logic      last;
      logic      finished;
   } pixel_rec_type;

   // Tracks the ellipse walk and holds the pixels still owed by the block.
   class ellipse_scoreboard;
      typedef enum logic [1:0] {
         WALK_IDLE,
         WALK_REGION1,
         WALK_REGION2_ENTRY,
         WALK_REGION2
      } walk_type;

      color_type     draw_color;
      walk_type      walk;
      longint        ctr_x, ctr_y, cur_x, cur_y, semi_a, semi_b;
      longint        a_sq, b_sq, grad_x, grad_y, decision;
      pixel_rec_type pixel_q[$];
      int            errors;

      function new();
         draw_color = '0;
         walk       = WALK_IDLE;
         errors     = 0;
      endfunction

      function bit busy();
         return walk != WALK_IDLE;
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction

      function void push_pixel(longint x, longint y, logic is_last, logic fin);
         pixel_rec_type p;
         p.px       = pix_type'(x);
         p.py       = pix_type'(y);
         p.color    = draw_color;
         p.last     = is_last;
         p.finished = fin;
         pixel_q.push_back(p);
      endfunction

      // Mirror order: (+x,+y), (-x,+y), (+x,-y), (-x,-y); the fourth closes the request.
      function void push_four(logic fin);
         push_pixel(ctr_x + cur_x, ctr_y + cur_y, 1'b0, 1'b0);
         push_pixel(ctr_x - cur_x, ctr_y + cur_y, 1'b0, 1'b0);
         push_pixel(ctr_x + cur_x, ctr_y - cur_y, 1'b0, 1'b0);
         push_pixel(ctr_x - cur_x, ctr_y - cur_y, 1'b1, fin);
      endfunction

      function void note_request(logic op, coord_type cx, coord_type cy,
                                 coord_type rx, coord_type ry);
         logic fin;
         if (op == OP_START) begin
            ctr_x    = longint'(cx);
            ctr_y    = longint'(cy);
            semi_a   = longint'(rx);
            semi_b   = longint'(ry);
            a_sq     = semi_a * semi_a;
            b_sq     = semi_b * semi_b;
            cur_x    = 0;
            cur_y    = semi_b;
            grad_x   = 0;
            grad_y   = 2 * a_sq * semi_b;
            decision = 4 * b_sq - 4 * a_sq * semi_b + a_sq;
            push_pixel(ctr_x, ctr_y, 1'b0, 1'b0);
            push_four(1'b0);
            walk = (grad_x < grad_y) ? WALK_REGION1 : WALK_REGION2_ENTRY;
         end else begin
            case (walk)
               WALK_REGION1: begin
                  cur_x  = cur_x + 1;
                  grad_x = grad_x + 2 * b_sq;
                  if (decision < 0) begin
                     decision = decision + 4 * grad_x + 4 * b_sq;
                  end else begin
                     cur_y    = cur_y - 1;
                     grad_y   = grad_y - 2 * a_sq;
                     decision = decision + 4 * grad_x - 4 * grad_y + 4 * b_sq;
                  end
                  push_four(1'b0);
                  if (!(grad_x < grad_y)) walk = WALK_REGION2_ENTRY;
               end
               WALK_REGION2_ENTRY: begin
                  cur_x    = semi_a;
                  cur_y    = 0;
                  grad_x   = 2 * b_sq * semi_a;
                  grad_y   = 0;
                  decision = 4 * a_sq - 4 * semi_a * b_sq + b_sq;
                  fin      = !(grad_x > grad_y);
                  walk     = fin ? WALK_IDLE : WALK_REGION2;
                  push_four(fin);
               end
               WALK_REGION2: begin
                  cur_y  = cur_y + 1;
                  grad_y = grad_y + 2 * a_sq;
                  if (decision < 0) begin
                     decision = decision + 4 * grad_y + 4 * a_sq;
                  end else begin
                     cur_x    = cur_x - 1;
                     grad_x   = grad_x - 2 * b_sq;
                     decision = decision + 4 * grad_y - 4 * grad_x + 4 * a_sq;
                  end
                  fin  = !(grad_x > grad_y);
                  walk = fin ? WALK_IDLE : WALK_REGION2;
                  push_four(fin);
               end
               default: ; // step with no ellipse active: no pixels
            endcase
         end
      endfunction

      function void check_pixel(pix_type px, pix_type py, color_type c,
                                logic is_last, logic fin);
         pixel_rec_type want;
         if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected pixel: x=%0d y=%0d color=%06h last=%0b finished=%0b",
                        px, py, c, is_last, fin);
            return;
         end
         want = pixel_q.pop_front();
         if (want.px !== px || want.py !== py || want.color !== c ||
             want.last !== is_last || want.finished !== fin) begin
            errors++;
            if (errors <= 10) begin
               $display("pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b fin=%0b",
                        want.px, want.py, want.color, want.last, want.finished);
               $display("                got      x=%0d y=%0d color=%06h last=%0b fin=%0b",
                        px, py, c, is_last, fin);
            end
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_opcode;
   coord_type req_center_x, req_center_y, req_radius_x, req_radius_y;
   logic      rsp_valid;
   logic      rsp_stall;
   pix_type   rsp_pixel_x, rsp_pixel_y;
   color_type rsp_color;
   logic      rsp_last;
   logic      rsp_finished;
   logic      csr_valid;
   logic      csr_ready;
   color_type csr_draw_color;

   ellipse_scoreboard sb = new();

   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_req;
   bit hold_done;
   int req_count;

   midpoint_ellipse_rasterizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_color      (rsp_color),
      .rsp_last       (rsp_last),
      .rsp_finished   (rsp_finished),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_draw_color (csr_draw_color)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_color, rsp_last, rsp_finished);
   end

   // Output side: random stall bursts, plus one long hold-off on demand.
   initial begin
      rsp_stall <= 1'b0;
      hold_done = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (250) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("midpoint_ellipse_rasterizer verification failed");
      $finish;
   end

   task automatic drive_request(input logic op, input coord_type cx, input coord_type cy,
                                input coord_type rx, input coord_type ry);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_x <= rx;
      req_radius_y <= ry;
      do @(posedge clock); while (req_stall);
      // steps with no ellipse active are ignored and not counted
      if (op == OP_START || sb.busy()) req_count++;
      sb.note_request(op, cx, cy, rx, ry);
   endtask

   task automatic step_noise();
      drive_request(OP_STEP, coord_type'($urandom_range(0, 4095)),
                    coord_type'($urandom_range(0, 4095)),
                    coord_type'($urandom_range(0, 4095)),
                    coord_type'($urandom_range(0, 4095)));
   endtask

   task automatic run_ellipse(input coord_type cx, input coord_type cy,
                              input coord_type a, input coord_type b, input int max_steps);
      int n;
      drive_request(OP_START, cx, cy, a, b);
      n = 0;
      while (sb.busy() && n < max_steps) begin
         step_noise();
         n++;
      end
   endtask

   task automatic random_ellipse();
      bit big;
      int a, b, steps;
      big = ($urandom_range(0, 15) == 0);
      a = big ? $urandom_range(0, 4095) : $urandom_range(0, 12);
      b = big ? $urandom_range(0, 4095) : $urandom_range(0, 12);
      if (big)
         steps = $urandom_range(1, 10);
      else
         steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 64;
      run_ellipse(coord_type'($urandom_range(0, 4095)), coord_type'($urandom_range(0, 4095)),
                  coord_type'(a), coord_type'(b), steps);
   endtask

   task automatic random_phase(input int n_items);
      int target;
      target = req_count + n_items;
      while (req_count < target) begin
         if ($urandom_range(0, 7) == 0)
            step_noise();
         else
            random_ellipse();
      end
   endtask

   // Waits until every owed pixel has come out, then lets idle steps settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_color(input color_type c);
      csr_valid      <= 1'b1;
      csr_draw_color <= c;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.draw_color = c;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_STEP;
      req_center_x   <= '0;
      req_center_y   <= '0;
      req_radius_x   <= '0;
      req_radius_y   <= '0;
      csr_valid      <= 1'b0;
      csr_draw_color <= '0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      hold_req       = 1'b0;
      req_count      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_color(24'h5A3C96);
      step_noise();                                // idle step
      run_ellipse(12'd0, 12'd0, 12'd0, 12'd0, 2);   // degenerate point
      step_noise();
      run_ellipse(12'd4095, 12'd4095, 12'd4095, 12'd4095, 3);
      run_ellipse(12'd0, 12'd0, 12'd4095, 12'd1, 3);  // restart while busy
      run_ellipse(12'd100, 12'd200, 12'd3, 12'd0, 3); // empty region 1
      run_ellipse(12'd7, 12'd9, 12'd0, 12'd5, 3);
      run_ellipse(12'd2048, 12'd1024, 12'd2, 12'd3, 20);
      run_ellipse(12'd0, 12'd4095, 12'd1, 12'd4095, 5); // early region switch

      drain();
      write_color(24'hFFFFFF);
      random_phase(50);

      drain();
      write_color(24'h000000);
      hold_req   = 1'b1;
      tx_idle_on = 1'b0;
      run_ellipse(coord_type'($urandom_range(0, 4095)), coord_type'($urandom_range(0, 4095)),
                  12'd10, 12'd10, 64);
      tx_idle_on = 1'b1;
      random_phase(50);

      drain();
      write_color(color_type'($urandom_range(0, 24'hFFFFFF)));
      rx_idle_on = 1'b0;
      random_phase(50);

      drain();
      write_color(color_type'($urandom_range(0, 24'hFFFFFF)));
      tx_idle_on = 1'b0;
      random_phase(50);

      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("midpoint_ellipse_rasterizer verification clean");
      else
         $display("midpoint_ellipse_rasterizer verification failed");
      $finish;
   end

endmodule
